/* rtl/core/pixel_dark_flat_calibration_top_defines.svh */
// assertion macros shared by the calibration checker
// no dependencies; include by bare file name
`ifndef PIXEL_DARK_FLAT_CALIBRATION_TOP_DEFINES_SVH
`define PIXEL_DARK_FLAT_CALIBRATION_TOP_DEFINES_SVH

// clocked property, muted while in reset
`define PDFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define PDFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/pdfc_pkg.sv */
// shared types and constants of the dark/bias/flat calibration pipeline
// no dependencies
package pdfc_pkg;

  localparam int PIX_W     = 16;
  localparam int LVL_W     = 22;
  localparam int GAIN_W    = 16;
  localparam int LFRAC     = 4;
  localparam int GFRAC     = 12;
  localparam int DIFF_W    = 24;
  localparam int NSHIFT    = GFRAC - LFRAC;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STGS  = QUO_W / DIV_STEPS;
  localparam int IN_W      = 80;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1 << GFRAC);
  localparam logic [PIX_W-1:0]  MAX_WIDE  = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0]  MAX_NARROW = PIX_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_EN = 2'd0,
    REG_DARK_EN = 2'd1,
    REG_FLAT_EN = 2'd2,
    REG_WIDE    = 2'd3
  } pdfc_reg_t;

  // one pixel in flight through the divider stages
  typedef struct packed {
    logic              bypass;
    logic              nonpos;
    logic              ovf;
    logic              wide;
    logic [PIX_W-1:0]  raw;
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0] rem;
    logic [QUO_W-1:0]  work;
  } pdfc_word_t;

endpackage

/* rtl/core/pdfc_div_stage.sv */
// four restoring division steps on one pixel word
// depends on pdfc_pkg
module pdfc_div_stage import pdfc_pkg::*; (
  input  pdfc_word_t din,
  output pdfc_word_t dout
);

  always_comb begin
    logic [GAIN_W:0] t;
    pdfc_word_t w;
    w = din;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {w.rem, w.work[QUO_W-1]};
      if (t >= {1'b0, w.gain}) begin
        w.rem  = GAIN_W'(t - {1'b0, w.gain});
        w.work = {w.work[QUO_W-2:0], 1'b1};
      end else begin
        w.rem  = t[GAIN_W-1:0];
        w.work = {w.work[QUO_W-2:0], 1'b0};
      end
    end
    dout = w;
  end

endmodule

/* rtl/core/pixel_dark_flat_calibration_top.sv */
// Pixel calibration: subtracts the enabled bias and dark levels, divides by the
// flat gain, rounds half to even and clamps to the pixel range; with all three
// corrections off the raw pixel passes unchanged. One pixel enters per clock
// when the output side does not stall. A level-subtract stage feeds the 16-step
// radix-2 divider, cut into four stages of four steps, then a round/clamp output
// register. Each stage holds its word until the next has room, so bubbles close
// up under backpressure. Configuration applies to words accepted after the write.
module pixel_dark_flat_calibration_top import pdfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // raw_pixel[15:0], bias_level[37:16], dark_level[59:38], flat_gain[75:60], zero pad
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // calibrated_pixel[15:0]
  output logic [PIX_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  logic bias_enable, dark_enable, flat_enable, wide_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_enable <= 1'b0;
      dark_enable <= 1'b0;
      flat_enable <= 1'b0;
      wide_pixels <= 1'b1;
    end else if (cfg_we) begin
      case (pdfc_reg_t'(cfg_index))
        REG_BIAS_EN: bias_enable <= cfg_data;
        REG_DARK_EN: dark_enable <= cfg_data;
        REG_FLAT_EN: flat_enable <= cfg_data;
        REG_WIDE:    wide_pixels <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  logic [PIX_W-1:0]  raw_pixel;
  logic [LVL_W-1:0]  bias_level, dark_level;
  logic [GAIN_W-1:0] flat_gain;

  assign raw_pixel  = s_tdata[PIX_W-1:0];
  assign bias_level = s_tdata[PIX_W+LVL_W-1:PIX_W];
  assign dark_level = s_tdata[PIX_W+2*LVL_W-1:PIX_W+LVL_W];
  assign flat_gain  = s_tdata[PIX_W+2*LVL_W+GAIN_W-1:PIX_W+2*LVL_W];

  // level subtraction
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-2:0]        diff_pos;
  pdfc_word_t               entry;

  always_comb begin
    logic signed [DIFF_W-1:0] raw_ext, bias_ext, dark_ext;
    raw_ext  = DIFF_W'({raw_pixel, {LFRAC{1'b0}}});
    bias_ext = bias_enable ? DIFF_W'($signed(bias_level)) : '0;
    dark_ext = dark_enable ? DIFF_W'($signed(dark_level)) : '0;
    diff     = raw_ext - bias_ext - dark_ext;
    diff_pos = diff[DIFF_W-2:0];

    entry.bypass = !(bias_enable || dark_enable || flat_enable);
    entry.nonpos = diff[DIFF_W-1] || (diff == '0);
    entry.ovf    = 1'b0;
    entry.wide   = wide_pixels;
    entry.raw    = raw_pixel;
    if (!flat_enable) begin
      entry.gain = GAIN_ONE;
    end else if (flat_gain == '0) begin
      entry.gain = GAIN_W'(1);
    end else begin
      entry.gain = flat_gain;
    end
    entry.rem  = GAIN_W'(diff_pos >> (QUO_W - NSHIFT));
    entry.work = {diff_pos[QUO_W-NSHIFT-1:0], {NSHIFT{1'b0}}};
  end

  // pipeline: stg[0] after subtract, stg[1..DIV_STGS] after divider stages
  pdfc_word_t            stg     [DIV_STGS+1];
  pdfc_word_t            div_in  [DIV_STGS];
  pdfc_word_t            div_out [DIV_STGS];
  logic [DIV_STGS:0]     vld;
  logic [DIV_STGS+1:0]   rdy;
  logic                  out_vld;
  logic [PIX_W-1:0]      out_pix;

  always_comb begin
    rdy[DIV_STGS+1] = !out_vld || m_tready;
    for (int k = DIV_STGS; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];

  // quotient would not fit in the result width
  always_comb begin
    for (int k = 0; k < DIV_STGS; k++) begin
      div_in[k] = stg[k];
    end
    div_in[0].ovf = stg[0].rem >= stg[0].gain;
  end

  for (genvar k = 0; k < DIV_STGS; k++) begin : g_div
    pdfc_div_stage u_div (
      .din  (div_in[k]),
      .dout (div_out[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k <= DIV_STGS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && s_tvalid) stg[0] <= entry;
    for (int k = 1; k <= DIV_STGS; k++) begin
      if (rdy[k] && vld[k-1]) stg[k] <= div_out[k-1];
    end
  end

  // round half to even, clamp
  logic [PIX_W-1:0] result;

  always_comb begin
    pdfc_word_t       w;
    logic             up;
    logic [QUO_W:0]   q_rnd;
    logic [PIX_W-1:0] maxval;
    w      = stg[DIV_STGS];
    up     = ({w.rem, 1'b0} > {1'b0, w.gain}) ||
             (({w.rem, 1'b0} == {1'b0, w.gain}) && w.work[0]);
    q_rnd  = {1'b0, w.work} + (QUO_W+1)'(up);
    maxval = w.wide ? MAX_WIDE : MAX_NARROW;
    if (w.bypass) begin
      result = w.raw;
    end else if (w.nonpos) begin
      result = '0;
    end else if (w.ovf || (q_rnd > {1'b0, maxval})) begin
      result = maxval;
    end else begin
      result = q_rnd[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (rdy[DIV_STGS+1]) begin
      out_vld <= vld[DIV_STGS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[DIV_STGS+1] && vld[DIV_STGS]) out_pix <= result;
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = out_pix;

endmodule

/* rtl/core/pdfc_checker.sv */
// port-level checks of the calibration pipeline, bound to the top level
// depends on pdfc_pkg and pixel_dark_flat_calibration_top_defines.svh
`include "pixel_dark_flat_calibration_top_defines.svh"

module pdfc_checker import pdfc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [PIX_W-1:0] m_tdata
);

  // a stalled output word holds
  `PDFC_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output word changed while stalled")

  // input side only backs up when every stage is full and the output stalls
  `PDFC_ASSERT(a_stall_cause, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")

  // reset empties the pipeline
  `PDFC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

bind pixel_dark_flat_calibration_top pdfc_checker u_pdfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
